// File: design/rrpr_pkg.sv
// Shared types, constants and helpers for the rotated region to pixel rectangle mapper.
package rrpr_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 1;
  localparam int SUM_W     = IN_W + 1;
  localparam int EXT_W     = 16;
  localparam int ORG_W     = 32;
  localparam int PROD_W    = IN_W + EXT_W;
  localparam int EDGE_W    = PROD_W + 1 - FRAC_BITS;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [IN_W-1:0]  ONE_FX      = IN_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] ONE_FX_SUM  = SUM_W'(1) << FRAC_BITS;
  localparam logic [PROD_W:0]  CEIL_BIAS   = (PROD_W + 1)'((1 << FRAC_BITS) - 1);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_SMALL   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  typedef enum logic [2:0] {
    REG_CONTENT_WIDTH  = 3'd0,
    REG_CONTENT_HEIGHT = 3'd1,
    REG_DOTS_PER_INCH  = 3'd2,
    REG_ORIGIN_X       = 3'd3,
    REG_ORIGIN_Y       = 3'd4,
    REG_MIN_WIDTH      = 3'd5,
    REG_MIN_HEIGHT     = 3'd6,
    REG_ROTATION       = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [EXT_W-1:0] content_width;
    logic [EXT_W-1:0] content_height;
    logic [EXT_W-1:0] dots_per_inch;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic [EXT_W-1:0] min_width;
    logic [EXT_W-1:0] min_height;
    rot_e             rotation;
  } cfg_t;

  // rotated edges in normalized units
  typedef struct packed {
    logic            invalid;
    logic [IN_W-1:0] tx;
    logic [IN_W-1:0] ty;
    logic [IN_W-1:0] tx_end;
    logic [IN_W-1:0] ty_end;
  } norm_t;

  typedef struct packed {
    logic              invalid;
    logic [PROD_W-1:0] prod_l;
    logic [PROD_W-1:0] prod_t;
    logic [PROD_W-1:0] prod_r;
    logic [PROD_W-1:0] prod_b;
  } prod_t;

  typedef struct packed {
    logic             invalid;
    logic [EXT_W-1:0] left;
    logic [EXT_W-1:0] top;
    logic [EXT_W-1:0] right;
    logic [EXT_W-1:0] bottom;
  } edge_t;

  function automatic logic [EXT_W-1:0] clamp_edge(input logic [EDGE_W-1:0] r,
                                                  input logic [EXT_W-1:0] ext);
    logic [EDGE_W-1:0] ext_w;
    ext_w = EDGE_W'(ext);
    return (r > ext_w) ? ext : r[EXT_W-1:0];
  endfunction

endpackage

// File: design/rotated_region_to_pixel_rect_top.sv
// Top level of the rotated region to pixel rectangle mapper.
// Accepts one normalized rectangle per cycle while the input is not stalled and
// returns its pixel rectangle through four registered stages: stage 1 checks bounds
// and rotates, stage 2 holds the edge-times-extent products of every edge, stage 3 floors,
// ceils and clamps, stage 4 forms the size, adds the desktop origin and holds the
// result. Each stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up while the output is stalled; the input stalls
// only when all four stages are full and the output is stalled. The user must write
// configuration through the APB port while no item is in flight; the block does not enforce it.
module rotated_region_to_pixel_rect_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrpr_pkg::ADDR_W-1:0] paddr,
  input  logic [rrpr_pkg::DATA_W-1:0] pwdata,
  output logic [rrpr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rrpr_pkg::IN_W-1:0]   norm_x_i,
  input  logic [rrpr_pkg::IN_W-1:0]   norm_y_i,
  input  logic [rrpr_pkg::IN_W-1:0]   norm_width_i,
  input  logic [rrpr_pkg::IN_W-1:0]   norm_height_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [rrpr_pkg::EXT_W-1:0]  src_left_o,
  output logic [rrpr_pkg::EXT_W-1:0]  src_top_o,
  output logic [rrpr_pkg::EXT_W-1:0]  src_width_o,
  output logic [rrpr_pkg::EXT_W-1:0]  src_height_o,
  output logic [rrpr_pkg::ORG_W-1:0]  overlay_x_o,
  output logic [rrpr_pkg::ORG_W-1:0]  overlay_y_o
);

  rrpr_pkg::cfg_t    cfg;
  rrpr_pkg::norm_t   norm_data;
  rrpr_pkg::edge_t   edge_data;
  rrpr_pkg::status_e status;
  logic              norm_valid, norm_stall, edge_valid, edge_stall;

  rrpr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrpr_norm u_norm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .valid_i       (in_valid_i),
    .stall_o       (in_stall_o),
    .norm_x_i      (norm_x_i),
    .norm_y_i      (norm_y_i),
    .norm_width_i  (norm_width_i),
    .norm_height_i (norm_height_i),
    .valid_o       (norm_valid),
    .stall_i       (norm_stall),
    .data_o        (norm_data)
  );

  rrpr_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (norm_valid),
    .stall_o (norm_stall),
    .data_i  (norm_data),
    .valid_o (edge_valid),
    .stall_i (edge_stall),
    .data_o  (edge_data)
  );

  rrpr_place u_place (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .valid_i      (edge_valid),
    .stall_o      (edge_stall),
    .data_i       (edge_data),
    .valid_o      (out_valid_o),
    .stall_i      (out_stall_i),
    .status_o     (status),
    .src_left_o   (src_left_o),
    .src_top_o    (src_top_o),
    .src_width_o  (src_width_o),
    .src_height_o (src_height_o),
    .overlay_x_o  (overlay_x_o),
    .overlay_y_o  (overlay_y_o)
  );

  assign status_o = status;

  // an invalid item carries no coordinates
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status == rrpr_pkg::STATUS_INVALID) |->
      (src_left_o == '0 && src_top_o == '0 && src_width_o == '0 &&
       src_height_o == '0 && overlay_x_o == '0 && overlay_y_o == '0))
    else $error("invalid item with nonzero coordinates");

  // input backpressure only when the output itself is held
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  // a full pipeline with the output released accepts again at once
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output not stalled");

endmodule

// File: design/rrpr_cfg.sv
// Configuration register file with APB-style access.
module rrpr_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rrpr_pkg::ADDR_W-1:0] paddr,
  input  logic [rrpr_pkg::DATA_W-1:0] pwdata,
  output logic [rrpr_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output rrpr_pkg::cfg_t              cfg_o
);

  rrpr_pkg::cfg_t   cfg_q;
  rrpr_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = rrpr_pkg::reg_idx_e'(paddr[rrpr_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.content_width  <= 16'd1920;
      cfg_q.content_height <= 16'd1080;
      cfg_q.dots_per_inch  <= 16'd96;
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.min_width      <= 16'd1;
      cfg_q.min_height     <= 16'd1;
      cfg_q.rotation       <= rrpr_pkg::ROT_0;
    end else if (wr_en) begin
      unique case (idx)
        rrpr_pkg::REG_CONTENT_WIDTH:  cfg_q.content_width  <= pwdata[rrpr_pkg::EXT_W-1:0];
        rrpr_pkg::REG_CONTENT_HEIGHT: cfg_q.content_height <= pwdata[rrpr_pkg::EXT_W-1:0];
        rrpr_pkg::REG_DOTS_PER_INCH:  cfg_q.dots_per_inch  <= pwdata[rrpr_pkg::EXT_W-1:0];
        rrpr_pkg::REG_ORIGIN_X:       cfg_q.origin_x       <= pwdata[rrpr_pkg::ORG_W-1:0];
        rrpr_pkg::REG_ORIGIN_Y:       cfg_q.origin_y       <= pwdata[rrpr_pkg::ORG_W-1:0];
        rrpr_pkg::REG_MIN_WIDTH:      cfg_q.min_width      <= pwdata[rrpr_pkg::EXT_W-1:0];
        rrpr_pkg::REG_MIN_HEIGHT:     cfg_q.min_height     <= pwdata[rrpr_pkg::EXT_W-1:0];
        rrpr_pkg::REG_ROTATION:       cfg_q.rotation       <= rrpr_pkg::rot_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rrpr_pkg::REG_CONTENT_WIDTH:  prdata = rrpr_pkg::DATA_W'(cfg_q.content_width);
      rrpr_pkg::REG_CONTENT_HEIGHT: prdata = rrpr_pkg::DATA_W'(cfg_q.content_height);
      rrpr_pkg::REG_DOTS_PER_INCH:  prdata = rrpr_pkg::DATA_W'(cfg_q.dots_per_inch);
      rrpr_pkg::REG_ORIGIN_X:       prdata = rrpr_pkg::DATA_W'(cfg_q.origin_x);
      rrpr_pkg::REG_ORIGIN_Y:       prdata = rrpr_pkg::DATA_W'(cfg_q.origin_y);
      rrpr_pkg::REG_MIN_WIDTH:      prdata = rrpr_pkg::DATA_W'(cfg_q.min_width);
      rrpr_pkg::REG_MIN_HEIGHT:     prdata = rrpr_pkg::DATA_W'(cfg_q.min_height);
      rrpr_pkg::REG_ROTATION:       prdata = rrpr_pkg::DATA_W'(cfg_q.rotation);
      default: ;
    endcase
  end

endmodule

// File: design/rrpr_norm.sv
// Stage 1: bounds and config checks, rotation in normalized space.
module rrpr_norm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rrpr_pkg::cfg_t            cfg_i,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic [rrpr_pkg::IN_W-1:0] norm_x_i,
  input  logic [rrpr_pkg::IN_W-1:0] norm_y_i,
  input  logic [rrpr_pkg::IN_W-1:0] norm_width_i,
  input  logic [rrpr_pkg::IN_W-1:0] norm_height_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output rrpr_pkg::norm_t           data_o
);

  logic                        valid_q;
  logic                        en;
  rrpr_pkg::norm_t             data_d, data_q;
  logic [rrpr_pkg::SUM_W-1:0]  x_end, y_end;
  logic [rrpr_pkg::SUM_W-1:0]  x_rev, y_rev;
  logic [rrpr_pkg::IN_W-1:0]   tx, ty, tw, th;
  logic [rrpr_pkg::SUM_W-1:0]  tx_end, ty_end;

  assign en      = !valid_q || !stall_i;
  assign stall_o = !en;

  always_comb begin
    x_end = rrpr_pkg::SUM_W'(norm_x_i) + rrpr_pkg::SUM_W'(norm_width_i);
    y_end = rrpr_pkg::SUM_W'(norm_y_i) + rrpr_pkg::SUM_W'(norm_height_i);
    // only meaningful when the rectangle is inside the unit square
    x_rev = rrpr_pkg::ONE_FX_SUM - x_end;
    y_rev = rrpr_pkg::ONE_FX_SUM - y_end;

    unique case (cfg_i.rotation)
      rrpr_pkg::ROT_90: begin
        tx = y_rev[rrpr_pkg::IN_W-1:0]; ty = norm_x_i;
        tw = norm_height_i;             th = norm_width_i;
      end
      rrpr_pkg::ROT_180: begin
        tx = x_rev[rrpr_pkg::IN_W-1:0]; ty = y_rev[rrpr_pkg::IN_W-1:0];
        tw = norm_width_i;              th = norm_height_i;
      end
      rrpr_pkg::ROT_270: begin
        tx = norm_y_i;                  ty = x_rev[rrpr_pkg::IN_W-1:0];
        tw = norm_height_i;             th = norm_width_i;
      end
      default: begin
        tx = norm_x_i;                  ty = norm_y_i;
        tw = norm_width_i;              th = norm_height_i;
      end
    endcase

    tx_end = rrpr_pkg::SUM_W'(tx) + rrpr_pkg::SUM_W'(tw);
    ty_end = rrpr_pkg::SUM_W'(ty) + rrpr_pkg::SUM_W'(th);

    data_d.invalid = (norm_width_i == '0) || (norm_height_i == '0) ||
                     (x_end > rrpr_pkg::ONE_FX_SUM) || (y_end > rrpr_pkg::ONE_FX_SUM) ||
                     (cfg_i.content_width == '0) || (cfg_i.content_height == '0) ||
                     (cfg_i.dots_per_inch == '0) || (cfg_i.min_width == '0) ||
                     (cfg_i.min_height == '0);
    data_d.tx     = tx;
    data_d.ty     = ty;
    data_d.tx_end = tx_end[rrpr_pkg::IN_W-1:0];
    data_d.ty_end = ty_end[rrpr_pkg::IN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: design/rrpr_scale.sv
// Stages 2 and 3: scale edges to pixels, then floor/ceil and clamp to the extent.
module rrpr_scale (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrpr_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            stall_o,
  input  rrpr_pkg::norm_t data_i,
  output logic            valid_o,
  input  logic            stall_i,
  output rrpr_pkg::edge_t data_o
);

  logic                         mul_valid_q, edge_valid_q;
  logic                         mul_en, edge_en, mid_stall;
  rrpr_pkg::prod_t              mul_d, mul_q;
  rrpr_pkg::edge_t              edge_d, edge_q;
  logic [rrpr_pkg::PROD_W:0]    r_bias, b_bias;
  logic [rrpr_pkg::EDGE_W-1:0]  l_raw, t_raw, r_raw, b_raw;

  assign edge_en   = !edge_valid_q || !stall_i;
  assign mid_stall = !edge_en;
  assign mul_en    = !mul_valid_q || !mid_stall;
  assign stall_o   = !mul_en;

  always_comb begin
    mul_d.invalid = data_i.invalid;
    mul_d.prod_l  = rrpr_pkg::PROD_W'(data_i.tx)     * rrpr_pkg::PROD_W'(cfg_i.content_width);
    mul_d.prod_r  = rrpr_pkg::PROD_W'(data_i.tx_end) * rrpr_pkg::PROD_W'(cfg_i.content_width);
    mul_d.prod_t  = rrpr_pkg::PROD_W'(data_i.ty)     * rrpr_pkg::PROD_W'(cfg_i.content_height);
    mul_d.prod_b  = rrpr_pkg::PROD_W'(data_i.ty_end) * rrpr_pkg::PROD_W'(cfg_i.content_height);
  end

  always_comb begin
    r_bias = (rrpr_pkg::PROD_W + 1)'(mul_q.prod_r) + rrpr_pkg::CEIL_BIAS;
    b_bias = (rrpr_pkg::PROD_W + 1)'(mul_q.prod_b) + rrpr_pkg::CEIL_BIAS;
    l_raw  = rrpr_pkg::EDGE_W'(mul_q.prod_l[rrpr_pkg::PROD_W-1:rrpr_pkg::FRAC_BITS]);
    t_raw  = rrpr_pkg::EDGE_W'(mul_q.prod_t[rrpr_pkg::PROD_W-1:rrpr_pkg::FRAC_BITS]);
    r_raw  = r_bias[rrpr_pkg::PROD_W:rrpr_pkg::FRAC_BITS];
    b_raw  = b_bias[rrpr_pkg::PROD_W:rrpr_pkg::FRAC_BITS];
    edge_d.invalid = mul_q.invalid;
    edge_d.left    = rrpr_pkg::clamp_edge(l_raw, cfg_i.content_width);
    edge_d.top     = rrpr_pkg::clamp_edge(t_raw, cfg_i.content_height);
    edge_d.right   = rrpr_pkg::clamp_edge(r_raw, cfg_i.content_width);
    edge_d.bottom  = rrpr_pkg::clamp_edge(b_raw, cfg_i.content_height);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q  <= 1'b0;
      edge_valid_q <= 1'b0;
    end else begin
      if (mul_en) begin
        mul_valid_q <= valid_i;
      end
      if (edge_en) begin
        edge_valid_q <= mul_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en && valid_i) begin
      mul_q <= mul_d;
    end
    if (edge_en && mul_valid_q) begin
      edge_q <= edge_d;
    end
  end

  assign valid_o = edge_valid_q;
  assign data_o  = edge_q;

endmodule

// File: design/rrpr_place.sv
// Stage 4: size, origin offset with overflow check, status and output register.
module rrpr_place (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rrpr_pkg::cfg_t             cfg_i,
  input  logic                       valid_i,
  output logic                       stall_o,
  input  rrpr_pkg::edge_t            data_i,
  output logic                       valid_o,
  input  logic                       stall_i,
  output rrpr_pkg::status_e          status_o,
  output logic [rrpr_pkg::EXT_W-1:0] src_left_o,
  output logic [rrpr_pkg::EXT_W-1:0] src_top_o,
  output logic [rrpr_pkg::EXT_W-1:0] src_width_o,
  output logic [rrpr_pkg::EXT_W-1:0] src_height_o,
  output logic [rrpr_pkg::ORG_W-1:0] overlay_x_o,
  output logic [rrpr_pkg::ORG_W-1:0] overlay_y_o
);

  logic                       valid_q, en;
  logic [rrpr_pkg::EXT_W-1:0] right_fix, bottom_fix, width, height;
  logic [rrpr_pkg::ORG_W:0]   sum_x, sum_y;
  logic                       bad;
  rrpr_pkg::status_e          status_d, status_q;
  logic [rrpr_pkg::EXT_W-1:0] left_d, top_d, width_d, height_d;
  logic [rrpr_pkg::EXT_W-1:0] left_q, top_q, width_q, height_q;
  logic [rrpr_pkg::ORG_W-1:0] ovl_x_d, ovl_y_d, ovl_x_q, ovl_y_q;

  assign en      = !valid_q || !stall_i;
  assign stall_o = !en;

  always_comb begin
    right_fix  = (data_i.right < data_i.left) ? data_i.left : data_i.right;
    bottom_fix = (data_i.bottom < data_i.top) ? data_i.top : data_i.bottom;
    width      = right_fix - data_i.left;
    height     = bottom_fix - data_i.top;
    // sign-extend origin, zero-extend edge; overflow when the top two bits differ
    sum_x = {cfg_i.origin_x[rrpr_pkg::ORG_W-1], cfg_i.origin_x} +
            (rrpr_pkg::ORG_W + 1)'(data_i.left);
    sum_y = {cfg_i.origin_y[rrpr_pkg::ORG_W-1], cfg_i.origin_y} +
            (rrpr_pkg::ORG_W + 1)'(data_i.top);
    bad   = data_i.invalid ||
            (sum_x[rrpr_pkg::ORG_W] != sum_x[rrpr_pkg::ORG_W-1]) ||
            (sum_y[rrpr_pkg::ORG_W] != sum_y[rrpr_pkg::ORG_W-1]);

    if (bad) begin
      status_d = rrpr_pkg::STATUS_INVALID;
      left_d   = '0;
      top_d    = '0;
      width_d  = '0;
      height_d = '0;
      ovl_x_d  = '0;
      ovl_y_d  = '0;
    end else begin
      status_d = ((width < cfg_i.min_width) || (height < cfg_i.min_height)) ?
                 rrpr_pkg::STATUS_SMALL : rrpr_pkg::STATUS_OK;
      left_d   = data_i.left;
      top_d    = data_i.top;
      width_d  = width;
      height_d = height;
      ovl_x_d  = sum_x[rrpr_pkg::ORG_W-1:0];
      ovl_y_d  = sum_y[rrpr_pkg::ORG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      status_q <= status_d;
      left_q   <= left_d;
      top_q    <= top_d;
      width_q  <= width_d;
      height_q <= height_d;
      ovl_x_q  <= ovl_x_d;
      ovl_y_q  <= ovl_y_d;
    end
  end

  assign valid_o      = valid_q;
  assign status_o     = status_q;
  assign src_left_o   = left_q;
  assign src_top_o    = top_q;
  assign src_width_o  = width_q;
  assign src_height_o = height_q;
  assign overlay_x_o  = ovl_x_q;
  assign overlay_y_o  = ovl_y_q;

endmodule
